// ===== rtl/dense_matrix_multiply_top_macros.svh =====
// Assertion helpers shared by the RTL that carries checks.
// Each expects clk and rst_n in scope.
`ifndef DENSE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define DENSE_MATRIX_MULTIPLY_TOP_MACROS_SVH

// Condition that must hold on every clock edge out of reset
`define DMM_CHECK(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dmm check failed");

// Condition that must hold in the cycle after a trigger
`define DMM_CHECK_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("dmm sequence check failed");

`endif

// ===== rtl/dmm_pkg.sv =====
`default_nettype none

package dmm_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int ELEM_W    = 16;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 35;
  localparam int IN_DATA_W  = 24;  // 22 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 48;  // 41 bits of fields, padded to bytes

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } dmm_state_t;

endpackage

`default_nettype wire

// ===== rtl/dense_matrix_multiply_top.sv =====
// Dense integer matrix multiplier.
// Input stream: in_tuser selects load A, load B or compute; in_tdata holds
// row, column and element value. Loads are taken one per cycle while idle and write one
// element of A or B. A compute item starts a run that emits every element of
// A x B in row-major order on the output stream, out_tlast on the final one.
// Config stream cfg_*: index 0 rows of A, 1 inner size, 2 columns of B.
// Write it only while the block is idle.
// Each product element uses one shared multiply-accumulate unit, fed by one
// read port on each store, for its inner-product steps, then read, multiply
// and result load; the next element starts only once the result is loaded.
// The input is not ready for the whole of a run; loads need no run.
// The result sits in an output register; a stalled receiver holds it and
// the run pauses before loading the next result until the register is free.
// Reset clears the sequencer, the output valid and the dimension registers
// (all 8); store contents are undefined until written.
`default_nettype none

module dense_matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dmm_pkg::IN_DATA_W-1:0]   in_tdata,  // row[2:0], col[5:3], value[21:6]
  input  wire logic [dmm_pkg::OP_W-1:0]        in_tuser,  // operation[1:0]
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [dmm_pkg::OUT_DATA_W-1:0]       out_tdata, // row[2:0], col[5:3], product[40:6]
  output logic                                 out_tlast,
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dmm_pkg::DIM_W-1:0]       cfg_data
);

  import dmm_pkg::*;

  `include "dense_matrix_multiply_top_macros.svh"

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int PW    = 2 * VALUE_BITS;

  // Dimension register, clamped to 1..MAX_DIM, returned as count minus one
  function automatic logic [CW-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_DIM) begin
      res = CW'(MAX_DIM - 1);
    end else begin
      res = CW'(v - DIM_W'(1));
    end
    return res;
  endfunction

  // Input field split
  logic [IDX_W-1:0]      in_row;
  logic [IDX_W-1:0]      in_col;
  logic [ELEM_W-1:0]     in_elem;
  logic [VALUE_BITS-1:0] elem_v;
  logic                  in_xfer;
  logic                  load_ok;
  logic [AW-1:0]         wr_addr;

  assign in_row  = in_tdata[IDX_W-1:0];
  assign in_col  = in_tdata[2*IDX_W-1:IDX_W];
  assign in_elem = in_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
  // Low VALUE_BITS of the field, zero-filled above the field
  assign elem_v  = VALUE_BITS'(in_elem);
  assign in_xfer = in_tvalid && in_tready;
  assign load_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_addr = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

  // Configuration registers
  logic [DIM_W-1:0] rows_r, inner_r, cols_r;
  logic [CW-1:0]    nr_m1, nk_m1, nc_m1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(8);
      inner_r <= DIM_W'(8);
      cols_r  <= DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_OF_A:  rows_r  <= cfg_data;
        REG_INNER_SIZE: inner_r <= cfg_data;
        REG_COLS_OF_B:  cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr_m1 = dim_last(rows_r);
  assign nk_m1 = dim_last(inner_r);
  assign nc_m1 = dim_last(cols_r);

  // Sequencer state and counters
  dmm_state_t state_r, state_nxt;
  logic [CW-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic rd_v_r, rd_last_r, mul_v_r, mul_last_r;

  logic start;
  logic issue;
  logic out_free;
  logic out_load;
  logic last_elem;

  assign start     = in_xfer && (in_tuser == OP_COMPUTE);
  assign out_free  = !out_tvalid || out_tready;
  assign last_elem = (r_r == nr_m1) && (c_r == nc_m1);

  // Store addresses for the current step
  logic [AW-1:0] a_addr, b_addr;
  assign a_addr = AW'(r_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_addr = AW'(k_r) * AW'(MAX_DIM) + AW'(c_r);

  // Stores: one write port for loads, one registered read port each
  logic signed [VALUE_BITS-1:0] mem_a [DEPTH];
  logic signed [VALUE_BITS-1:0] mem_b [DEPTH];
  logic signed [VALUE_BITS-1:0] a_q_r, b_q_r;

  always_ff @(posedge clk) begin
    if (in_xfer && load_ok && (in_tuser == OP_LOAD_A)) begin
      mem_a[wr_addr] <= elem_v;
    end
    if (issue) begin
      a_q_r <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && load_ok && (in_tuser == OP_LOAD_B)) begin
      mem_b[wr_addr] <= elem_v;
    end
    if (issue) begin
      b_q_r <= mem_b[b_addr];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (k_r == nk_m1) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (mul_v_r && mul_last_r) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = last_elem ? ST_IDLE : ST_ISSUE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State decode
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_ISSUE: issue     = 1'b1;
      ST_EMIT:  out_load  = out_free;
      default: ;
    endcase
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate
  logic signed [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r     <= 1'b0;
      rd_last_r  <= 1'b0;
      mul_v_r    <= 1'b0;
      mul_last_r <= 1'b0;
    end else begin
      rd_v_r     <= issue;
      rd_last_r  <= issue && (k_r == nk_m1);
      mul_v_r    <= rd_v_r;
      mul_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= a_q_r * b_q_r;
    end
  end

  // Counters and accumulator
  always_comb begin
    r_nxt   = r_r;
    c_nxt   = c_r;
    k_nxt   = k_r;
    acc_nxt = acc_r;
    if (start) begin
      r_nxt   = '0;
      c_nxt   = '0;
      k_nxt   = '0;
      acc_nxt = '0;
    end
    if (issue) begin
      k_nxt = (k_r == nk_m1) ? '0 : k_r + CW'(1);
    end
    if (mul_v_r) begin
      acc_nxt = acc_r + PROD_W'(prod_r);
    end
    if (out_load) begin
      acc_nxt = '0;
      k_nxt   = '0;
      if (c_r == nc_m1) begin
        c_nxt = '0;
        r_nxt = r_r + CW'(1);
      end else begin
        c_nxt = c_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Output register
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [PROD_W-1:0] out_val_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= IDX_W'(r_r);
      out_col_r  <= IDX_W'(c_r);
      out_val_r  <= acc_r;
      out_last_r <= last_elem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - 2*IDX_W - PROD_W)'(0), out_val_r, out_col_r, out_row_r};

  // Checks
  `DMM_CHECK_NEXT(a_last_returns_idle, out_load && last_elem, state_r == ST_IDLE)
  `DMM_CHECK(a_pipe_only_in_run, !mul_v_r || state_r == ST_ISSUE || state_r == ST_DRAIN)
  `DMM_CHECK(a_k_in_range, k_r <= nk_m1)

endmodule

`default_nettype wire
